/* rtl/core/sew_pkg.sv */
// shared types, constants and helpers of the segment energy weighting block
package sew_pkg;

    localparam int NUM_LANES  = 8;
    localparam int LANE_W     = 3;
    localparam int CNT_W      = 7;
    localparam int SAMPLE_W   = 16;
    localparam int ENERGY_W   = 48;
    localparam int TARGET_W   = 32;
    localparam int BW_W       = 16;
    localparam int NUM_W      = 48;
    localparam int QUOT_W     = 62;
    localparam int ROOT_W     = 63;
    localparam int SCALE_W    = 31;
    localparam int PROD_W     = 47;
    localparam int DIV_STEPS  = 78;
    localparam int DIV_PAD    = 30;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_W     = 7;

    localparam logic [QUOT_W-1:0] QCAP      = '1;
    localparam logic [QUOT_W-1:0] QCAP_HALF = QCAP >> 1;

    // item codes and register indexes
    localparam logic FUNC_CLOSE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;
    localparam logic CFG_BW_LOW  = 1'b0;
    localparam logic CFG_BW_HIGH = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [31:0] band_value_0;
        logic signed [31:0] band_value_1;
        logic signed [31:0] band_value_2;
        logic signed [31:0] band_value_3;
        logic signed [31:0] band_value_4;
        logic signed [31:0] band_value_5;
        logic signed [31:0] band_value_6;
        logic signed [31:0] band_value_7;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] scaled_0;
        logic signed [15:0] scaled_1;
        logic signed [15:0] scaled_2;
        logic signed [15:0] scaled_3;
        logic signed [15:0] scaled_4;
        logic signed [15:0] scaled_5;
        logic signed [15:0] scaled_6;
        logic signed [15:0] scaled_7;
        logic               last_of_segment;
        logic [7:0]         silent_bands;
    } out_item_t;

    typedef logic [NUM_LANES-1:0][SAMPLE_W-1:0] row_t;
    typedef logic [NUM_LANES-1:0][BW_W-1:0]     bw_set_t;

    // one closed segment handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0]                         count;
        logic [NUM_LANES-1:0][ENERGY_W-1:0]       energy;
        logic [NUM_LANES-1:0][TARGET_W-1:0]       target;
    } job_t;

    // saturate a 32-bit value to 16-bit two's complement
    function automatic logic [SAMPLE_W-1:0] sat16(input logic signed [31:0] v);
        logic [SAMPLE_W-1:0] r;
        if (v > 32'sd32767) begin
            r = 16'h7fff;
        end else if (v < -32'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/segment_energy_weighting_core.sv */
// top level of the segment energy weighting block
//
// Input channel s_*: items with func=1 are samples of eight bands; each is
// stored (up to MAX_SEGMENT per segment, later ones dropped) and its squares
// are summed per band, one sample per cycle while s_ready is high. An item
// with func=0 carries the target energies and closes the segment.
// After a close the back end works band by band: it forms the numerator,
// then runs bit-serial division and integer square root for an active band
// and only marks a silent band. It then emits one result per stored sample
// on m_*, the last one flagged by last_of_segment, and handles the samples
// one at a time: store read, multiply, round, then the next store read.
// s_ready is low from a close until the back end has read the whole segment.
// A stalled receiver holds the output register and the emission waits.
// cfg_*: bandwidth registers; the user must write them only while the block
// is idle, and the block itself does not enforce it.
// Reset (aresetn low, synchronous) clears energies, counts, queue and the
// output valid; the sample store is not cleared and needs no clearing pass.
module segment_energy_weighting_core import sew_pkg::*; #(
    parameter int MAX_SEGMENT = 64,
    parameter int BANDS       = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wr_data
);

    localparam int AW = (MAX_SEGMENT > 1) ? $clog2(MAX_SEGMENT) : 1;

    logic [63:0]   bw_low_reg;
    logic [63:0]   bw_high_reg;
    bw_set_t       bw;
    logic          hold;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    row_t          ram_wdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    row_t          rd_data;
    logic          push;
    job_t          push_job;
    logic          pop;
    logic          job_valid;
    job_t          head;
    logic          back_busy;

    // bandwidth registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_low_reg  <= '0;
            bw_high_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BW_LOW:  bw_low_reg  <= cfg_wr_data;
                CFG_BW_HIGH: bw_high_reg <= cfg_wr_data;
                default:     bw_low_reg  <= bw_low_reg;
            endcase
        end
    end

    assign bw   = {bw_high_reg, bw_low_reg};
    assign hold = job_valid || back_busy;

    sew_front #(
        .MAX_SEGMENT(MAX_SEGMENT),
        .BANDS      (BANDS),
        .AW         (AW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .hold     (hold),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .push     (push),
        .job      (push_job)
    );

    sew_ram #(
        .WIDTH($bits(row_t)),
        .DEPTH(MAX_SEGMENT),
        .AW   (AW)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    sew_job_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .nonempty(job_valid),
        .head    (head)
    );

    sew_back #(
        .BANDS(BANDS),
        .AW   (AW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_valid(job_valid),
        .job_in   (head),
        .pop      (pop),
        .bw       (bw),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .busy     (back_busy),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

/* rtl/core/sew_ram.sv */
// generic single-write, single-read ram with registered read data
module sew_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/sew_front.sv */
// front end: takes items, stores samples, sums band energies, closes segments
module sew_front import sew_pkg::*; #(
    parameter int MAX_SEGMENT = 64,
    parameter int BANDS       = 8,
    parameter int AW          = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_item_t      s_item,
    input  logic          hold,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output row_t          ram_wdata,
    output logic          push,
    output job_t          job
);

    logic [NUM_LANES-1:0][TARGET_W-1:0] vals;
    row_t                               row;
    logic [NUM_LANES-1:0][ENERGY_W-1:0] energy_reg;
    logic [NUM_LANES-1:0][ENERGY_W-1:0] energy_next;
    logic [CNT_W-1:0]                   count_reg;
    logic                               accept;
    logic                               is_sample;
    logic                               store_ok;

    assign vals = {s_item.band_value_7, s_item.band_value_6, s_item.band_value_5,
                   s_item.band_value_4, s_item.band_value_3, s_item.band_value_2,
                   s_item.band_value_1, s_item.band_value_0};

    // handshake and item kind
    assign s_ready   = !hold;
    assign accept    = s_valid && s_ready;
    assign is_sample = (s_item.func == FUNC_SAMPLE);
    assign store_ok  = (count_reg < CNT_W'(MAX_SEGMENT));

    // saturate samples and add their squares
    always_comb begin
        logic signed [31:0] sq;
        for (int b = 0; b < NUM_LANES; b++) begin
            row[b] = (b < BANDS) ? sat16(vals[b]) : '0;
            sq = $signed(row[b]) * $signed(row[b]);
            energy_next[b] = energy_reg[b] + ENERGY_W'(unsigned'(sq));
        end
    end

    // store write
    assign ram_we    = accept && is_sample && store_ok;
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = row;

    // segment close
    assign push       = accept && !is_sample;
    assign job.count  = count_reg;
    assign job.energy = energy_reg;
    assign job.target = vals;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg <= '0;
            count_reg  <= '0;
        end else if (push) begin
            energy_reg <= '0;
            count_reg  <= '0;
        end else if (ram_we) begin
            energy_reg <= energy_next;
            count_reg  <= count_reg + CNT_W'(1);
        end
    end

endmodule

/* rtl/core/sew_job_queue.sv */
// two-entry queue of closed segments between front and back
module sew_job_queue import sew_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic nonempty,
    output job_t head
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign nonempty = (fill_reg != 2'd0);
    assign head     = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push && fill_reg != 2'd2) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        logic do_push;
        logic do_pop;
        do_push = push && (fill_reg != 2'd2);
        do_pop  = pop && nonempty;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/core/sew_back.sv */
// back end: per-band scale by bit-serial divide and root, then row emission
module sew_back import sew_pkg::*; #(
    parameter int BANDS = 8,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    input  job_t          job_in,
    output logic          pop,
    input  bw_set_t       bw,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  row_t          rd_data,
    output logic          busy,
    output logic          m_valid,
    input  logic          m_ready,
    output out_item_t     m_item
);

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_PREP = 7'b0000010,
        B_DIV  = 7'b0000100,
        B_SQRT = 7'b0001000,
        B_READ = 7'b0010000,
        B_PROD = 7'b0100000,
        B_OUT  = 7'b1000000
    } back_state_t;

    back_state_t                         state_reg;
    back_state_t                         state_next;
    job_t                                job_reg;
    logic [LANE_W-1:0]                   band_reg;
    logic [CNT_W-1:0]                    row_reg;
    logic [STEP_W-1:0]                   step_reg;
    logic [NUM_W+DIV_PAD-1:0]            num_sh_reg;
    logic [ENERGY_W-1:0]                 rem_reg;
    logic [QUOT_W-1:0]                   quot_reg;
    logic [ROOT_W-1:0]                   x_reg;
    logic [ROOT_W-1:0]                   res_reg;
    logic [ROOT_W-1:0]                   bit_reg;
    logic [NUM_LANES-1:0][SCALE_W-1:0]   scale_reg;
    logic [NUM_LANES-1:0]                silent_reg;
    logic [NUM_LANES-1:0][PROD_W-1:0]    prod_reg;
    logic [NUM_LANES-1:0]                neg_reg;
    out_item_t                           out_reg;
    logic                                out_valid_reg;

    logic [ENERGY_W-1:0]                 denom;
    logic                                band_live;
    logic                                last_band;
    logic [NUM_W-1:0]                    num;
    logic [ENERGY_W:0]                   trial;
    logic                                div_ge;
    logic [ENERGY_W-1:0]                 rem_new;
    logic [QUOT_W-1:0]                   quot_new;
    logic                                div_cap;
    logic [ROOT_W:0]                     root_sum;
    logic                                root_ge;
    logic [ROOT_W-1:0]                   res_new;
    logic [ROOT_W-1:0]                   x_new;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0]  lane_out;
    logic                                out_free;
    logic                                last_row;

    assign denom     = job_reg.energy[band_reg];
    assign band_live = (32'(band_reg) < BANDS) && (denom != '0);
    assign last_band = (band_reg == LANE_W'(NUM_LANES - 1));
    assign last_row  = (row_reg + CNT_W'(1) == job_reg.count);
    assign out_free  = !out_valid_reg || m_ready;

    // numerator 2 * target * bandwidth, negative target taken as zero
    always_comb begin
        logic [TARGET_W-2:0] e_pos;
        logic [PROD_W-1:0]   mul;
        e_pos = job_reg.target[band_reg][TARGET_W-1] ? '0
                                                      : job_reg.target[band_reg][TARGET_W-2:0];
        mul   = e_pos * bw[band_reg];
        num   = {mul, 1'b0};
    end

    // one restoring division step
    always_comb begin
        trial    = {rem_reg, num_sh_reg[NUM_W+DIV_PAD-1]} - {1'b0, denom};
        div_ge   = !trial[ENERGY_W];
        rem_new  = div_ge ? trial[ENERGY_W-1:0] : {rem_reg[ENERGY_W-2:0],
                                                   num_sh_reg[NUM_W+DIV_PAD-1]};
        quot_new = {quot_reg[QUOT_W-2:0], div_ge};
        div_cap  = (quot_reg > QCAP_HALF);
    end

    // one integer square root step
    always_comb begin
        root_sum = {1'b0, res_reg} + {1'b0, bit_reg};
        root_ge  = ({1'b0, x_reg} >= root_sum);
        x_new    = root_ge ? (x_reg - root_sum[ROOT_W-1:0]) : x_reg;
        res_new  = root_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
    end

    // rounding and saturation of each lane
    always_comb begin
        logic [PROD_W:0]          rnd;
        logic [PROD_W-16:0]       mag;
        logic [SAMPLE_W:0]        capped;
        logic signed [SAMPLE_W:0] val;
        for (int b = 0; b < NUM_LANES; b++) begin
            rnd    = {1'b0, prod_reg[b]} + (PROD_W+1)'(16'h8000);
            mag    = rnd[PROD_W:16];
            capped = (mag > (PROD_W-15)'(32768)) ? 17'd32768 : mag[SAMPLE_W:0];
            val    = neg_reg[b] ? -$signed(capped) : $signed(capped);
            if (val > 17'sd32767) begin
                val = 17'sd32767;
            end
            lane_out[b] = silent_reg[b] ? '0 : val[SAMPLE_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (job_valid) begin
                    state_next = B_PREP;
                end
            end
            B_PREP: begin
                if (band_live) begin
                    state_next = B_DIV;
                end else if (last_band) begin
                    state_next = (job_reg.count == '0) ? B_IDLE : B_READ;
                end
            end
            B_DIV: begin
                if (div_cap || step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = B_SQRT;
                end
            end
            B_SQRT: begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    if (!last_band) begin
                        state_next = B_PREP;
                    end else begin
                        state_next = (job_reg.count == '0) ? B_IDLE : B_READ;
                    end
                end
            end
            B_READ: state_next = B_PROD;
            B_PROD: state_next = B_OUT;
            B_OUT: begin
                if (out_free) begin
                    state_next = last_row ? B_IDLE : B_READ;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                job_reg    <= job_in;
                band_reg   <= '0;
                row_reg    <= '0;
                silent_reg <= '0;
            end
            B_PREP: begin
                num_sh_reg <= {num, DIV_PAD'(0)};
                rem_reg    <= '0;
                quot_reg   <= '0;
                step_reg   <= '0;
                if (!band_live) begin
                    scale_reg[band_reg]  <= '0;
                    silent_reg[band_reg] <= (32'(band_reg) < BANDS);
                    band_reg             <= band_reg + LANE_W'(1);
                    row_reg              <= '0;
                end
            end
            B_DIV: begin
                res_reg <= '0;
                bit_reg <= ROOT_W'(1) << (ROOT_W - 1);
                if (div_cap) begin
                    x_reg    <= {1'b0, QCAP};
                    step_reg <= '0;
                end else begin
                    rem_reg    <= rem_new;
                    quot_reg   <= quot_new;
                    num_sh_reg <= num_sh_reg << 1;
                    x_reg      <= {1'b0, quot_new};
                    step_reg   <= (step_reg == STEP_W'(DIV_STEPS - 1)) ? '0
                                                                      : step_reg + STEP_W'(1);
                end
            end
            B_SQRT: begin
                x_reg    <= x_new;
                res_reg  <= res_new;
                bit_reg  <= bit_reg >> 2;
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    scale_reg[band_reg] <= res_new[SCALE_W-1:0];
                    band_reg            <= band_reg + LANE_W'(1);
                end
            end
            B_PROD: begin
                for (int b = 0; b < NUM_LANES; b++) begin
                    logic [SAMPLE_W-1:0] mag16;
                    mag16       = rd_data[b][SAMPLE_W-1] ? -rd_data[b] : rd_data[b];
                    neg_reg[b]  <= rd_data[b][SAMPLE_W-1];
                    prod_reg[b] <= mag16 * scale_reg[b];
                end
            end
            B_OUT: begin
                if (out_free) begin
                    row_reg <= row_reg + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (state_reg == B_OUT && out_free) begin
            out_reg.scaled_0        <= lane_out[0];
            out_reg.scaled_1        <= lane_out[1];
            out_reg.scaled_2        <= lane_out[2];
            out_reg.scaled_3        <= lane_out[3];
            out_reg.scaled_4        <= lane_out[4];
            out_reg.scaled_5        <= lane_out[5];
            out_reg.scaled_6        <= lane_out[6];
            out_reg.scaled_7        <= lane_out[7];
            out_reg.last_of_segment <= last_row;
            out_reg.silent_bands    <= silent_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == B_OUT && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign pop     = (state_reg == B_IDLE) && job_valid;
    assign busy    = (state_reg != B_IDLE);
    assign rd_en   = (state_reg == B_READ);
    assign rd_addr = row_reg[AW-1:0];
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

/* rtl/core/sew_checker.sv */
// port-level checker of the segment energy weighting block, bound to the top
module sew_checker import sew_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input in_item_t    s_item,
    input logic        m_valid,
    input logic        m_ready,
    input out_item_t   m_item
);

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a silent band always reads as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((!m_item.silent_bands[0] || m_item.scaled_0 == 16'sd0) &&
                     (!m_item.silent_bands[1] || m_item.scaled_1 == 16'sd0) &&
                     (!m_item.silent_bands[2] || m_item.scaled_2 == 16'sd0) &&
                     (!m_item.silent_bands[3] || m_item.scaled_3 == 16'sd0) &&
                     (!m_item.silent_bands[4] || m_item.scaled_4 == 16'sd0) &&
                     (!m_item.silent_bands[5] || m_item.scaled_5 == 16'sd0) &&
                     (!m_item.silent_bands[6] || m_item.scaled_6 == 16'sd0) &&
                     (!m_item.silent_bands[7] || m_item.scaled_7 == 16'sd0)))
        else $error("silent band with nonzero output");

    // a close shuts the input (s_ready low once the close has been taken)
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.func == FUNC_CLOSE |=> !s_ready)
        else $error("input open right after a segment close");

endmodule

bind segment_energy_weighting_core sew_checker u_sew_checker (.*);

/* tb/testbench.sv */
// self-checking testbench for the segment energy weighting core
`timescale 1ns / 1ps

module testbench;
    import sew_pkg::*;

    localparam int SEG_MAX   = 64;
    localparam int CYCLE_CAP = 1500000;
    localparam int DRAIN_GAP = 1200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_BW_LOW;
    logic [63:0] cfg_wr_data = '0;

    segment_energy_weighting_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    // predictor state
    logic [63:0]          bw_low_q, bw_high_q;
    logic signed [15:0]   seg_samples [SEG_MAX][8];
    logic [63:0]          seg_energy [8];
    int unsigned          seg_count;

    in_item_t  pending_items [$];
    out_item_t scaled_rows [$];
    int        error_count, rows_seen, closes_sent, cycle_count;
    int        send_idle_pct, recv_idle_pct;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic signed [31:0] band_of(in_item_t it, int b);
        case (b)
            0: return it.band_value_0;
            1: return it.band_value_1;
            2: return it.band_value_2;
            3: return it.band_value_3;
            4: return it.band_value_4;
            5: return it.band_value_5;
            6: return it.band_value_6;
            default: return it.band_value_7;
        endcase
    endfunction

    function automatic logic [15:0] scaled_of(out_item_t it, int b);
        case (b)
            0: return it.scaled_0;
            1: return it.scaled_1;
            2: return it.scaled_2;
            3: return it.scaled_3;
            4: return it.scaled_4;
            5: return it.scaled_5;
            6: return it.scaled_6;
            default: return it.scaled_7;
        endcase
    endfunction

    // floor((num << 30) / den), capped at 2^62-1
    function automatic logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, num} << 30) / {64'd0, den};
        if (q > 128'h3fffffffffffffff) return 64'h3fffffffffffffff;
        return q[63:0];
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] x);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (x >= res + bit_v) begin
                x = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // absorb one accepted item, queueing any scaled rows it releases
    task automatic weigh_item(in_item_t it);
        logic [63:0]        gain [8];
        logic [7:0]         silent;
        logic signed [31:0] v;
        logic [63:0]        tgt, bw, mag, m;
        logic signed [16:0] r;
        out_item_t          row;
        silent = '0;
        if (it.func == FUNC_SAMPLE) begin
            if (seg_count < SEG_MAX) begin
                for (int b = 0; b < 8; b++) begin
                    v = band_of(it, b);
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                    seg_samples[seg_count][b] = v[15:0];
                    seg_energy[b] += 64'(v * v);
                end
                seg_count++;
            end
            return;
        end
        for (int b = 0; b < 8; b++) begin
            gain[b] = 0;
            if (seg_energy[b] == 0) begin
                silent[b] = 1'b1;
            end else begin
                v = band_of(it, b);
                tgt = (v < 0) ? 64'd0 : 64'(v);
                bw = ((b < 4 ? bw_low_q : bw_high_q) >> (16 * (b % 4))) & 64'hffff;
                gain[b] = int_root(scaled_quotient(2 * tgt * bw, seg_energy[b]));
            end
        end
        for (int k = 0; k < seg_count; k++) begin
            row = '0;
            for (int b = 0; b < 8; b++) begin
                mag = (seg_samples[k][b] < 0) ? 64'(-(32'(seg_samples[k][b])))
                                              : 64'(seg_samples[k][b]);
                m = (mag * gain[b] + 64'h8000) >> 16;
                if (m > 32768) m = 32768;
                r = (seg_samples[k][b] < 0) ? -17'(m) : 17'(m);
                if (r > 32767) r = 32767;
                if (silent[b]) r = 0;
                case (b)
                    0: row.scaled_0 = r[15:0];
                    1: row.scaled_1 = r[15:0];
                    2: row.scaled_2 = r[15:0];
                    3: row.scaled_3 = r[15:0];
                    4: row.scaled_4 = r[15:0];
                    5: row.scaled_5 = r[15:0];
                    6: row.scaled_6 = r[15:0];
                    default: row.scaled_7 = r[15:0];
                endcase
            end
            row.last_of_segment = (k + 1 == seg_count);
            row.silent_bands = silent;
            scaled_rows.push_back(row);
        end
        for (int b = 0; b < 8; b++) seg_energy[b] = 0;
        seg_count = 0;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at row %0d: %s got %h expected %h", rows_seen, what, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready) weigh_item(s_item);
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_item  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (scaled_rows.size() == 0) begin
                    $display("unexpected row %h", m_item);
                    error_count++;
                end else begin
                    out_item_t want;
                    want = scaled_rows.pop_front();
                    for (int b = 0; b < 8; b++)
                        if (scaled_of(m_item, b) !== scaled_of(want, b))
                            report_mismatch($sformatf("scaled_%0d", b),
                                            scaled_of(m_item, b), scaled_of(want, b));
                    if (m_item.last_of_segment !== want.last_of_segment)
                        report_mismatch("last_of_segment", m_item.last_of_segment,
                                        want.last_of_segment);
                    if (m_item.silent_bands !== want.silent_bands)
                        report_mismatch("silent_bands", m_item.silent_bands,
                                        want.silent_bands);
                end
                rows_seen++;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic in_item_t make_item(logic func, logic signed [31:0] vals [8]);
        in_item_t it;
        it.func = func;
        it.band_value_0 = vals[0]; it.band_value_1 = vals[1];
        it.band_value_2 = vals[2]; it.band_value_3 = vals[3];
        it.band_value_4 = vals[4]; it.band_value_5 = vals[5];
        it.band_value_6 = vals[6]; it.band_value_7 = vals[7];
        return it;
    endfunction

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 0;
            2: return 32767;
            3: return -32768;
            default: return $signed(32'($urandom_range(65535))) - 32768;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_target();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 0;
            2: return 32'h7fffffff;
            default: return $urandom_range(32'h0100_0000);
        endcase
    endfunction

    task automatic write_reg(logic idx, logic [63:0] data);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        bw_low_q    = (idx == CFG_BW_LOW) ? data : bw_low_q;
        bw_high_q   = (idx == CFG_BW_HIGH) ? data : bw_high_q;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || scaled_rows.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    // random segment: mostly sample runs then a close, sometimes a lone close
    task automatic queue_segment(int len);
        logic signed [31:0] vals [8];
        for (int k = 0; k < len; k++) begin
            for (int b = 0; b < 8; b++) vals[b] = rand_sample();
            if ($urandom_range(5) == 0) vals[$urandom_range(7)] = 0;
            pending_items.push_back(make_item(FUNC_SAMPLE, vals));
        end
        for (int b = 0; b < 8; b++) vals[b] = rand_target();
        pending_items.push_back(make_item(FUNC_CLOSE, vals));
        closes_sent++;
    endtask

    initial begin
        logic signed [31:0] vals [8];
        int                 sent;
        bw_low_q = 0; bw_high_q = 0;
        seg_count = 0;
        for (int b = 0; b < 8; b++) seg_energy[b] = 0;
        error_count = 0; rows_seen = 0; closes_sent = 0; cycle_count = 0;
        send_idle_pct = 9; recv_idle_pct = 68;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero bandwidths first, empty close, then extremes
        for (int b = 0; b < 8; b++) vals[b] = 32'h7fffffff;
        pending_items.push_back(make_item(FUNC_CLOSE, vals));
        for (int b = 0; b < 8; b++) vals[b] = 32767;
        pending_items.push_back(make_item(FUNC_SAMPLE, vals));
        pending_items.push_back(make_item(FUNC_CLOSE, vals));
        wait_idle();
        write_reg(CFG_BW_LOW, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_BW_HIGH, 64'hffff_ffff_ffff_ffff);
        vals = '{32'sh7fffffff, 32'sh80000000, 32767, -32768, 1, -1, 0, 32'sh00012345};
        pending_items.push_back(make_item(FUNC_SAMPLE, vals));
        vals = '{-32768, 32767, 0, 0, 100, -100, 0, 5};
        pending_items.push_back(make_item(FUNC_SAMPLE, vals));
        // targets: max, zero, negative, small, typical
        vals = '{32'sh7fffffff, 0, -5, 1, 32'sh00010000, 32'sh80000000, 7, 32'sh00400000};
        pending_items.push_back(make_item(FUNC_CLOSE, vals));
        // overfull segment: samples past the limit are dropped
        queue_segment(SEG_MAX + 3);
        wait_idle();
        write_reg(CFG_BW_LOW, 64'h0001_8000_4000_0100);
        write_reg(CFG_BW_HIGH, 64'h1234_0800_0200_ffff);

        // random phases with different idling and bandwidths
        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 68; recv_idle_pct = 9;
            end else if (phase == 2) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            for (int s = 0; s < 2; s++) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(SEG_MAX) : $urandom_range(6);
                queue_segment(len);
                sent += len + 1;
            end
            wait_idle();
            write_reg(CFG_BW_LOW, {$urandom, $urandom});
            write_reg(CFG_BW_HIGH, {$urandom, $urandom});
        end
        while (sent < 30 || rows_seen < 40) begin
            int len;
            len = $urandom_range(1, 6);
            queue_segment(len);
            sent += len + 1;
            wait_idle();
        end
        wait_idle();

        $display("covered %0d segment closes and %0d scaled rows, %0d mismatches",
                 closes_sent, rows_seen, error_count);
        if (error_count == 0 && scaled_rows.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/sew_pkg.sv
rtl/core/sew_ram.sv
rtl/core/sew_front.sv
rtl/core/sew_job_queue.sv
rtl/core/sew_back.sv
rtl/core/segment_energy_weighting_core.sv
rtl/core/sew_checker.sv
tb/testbench.sv
